>>> hw/rtl/qlh_pkg.sv
// ----------------------------------------------------------------------------
// qlh_pkg
// Shared types and constants for the QUIC long header length parser.
// ----------------------------------------------------------------------------
package qlh_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK           = 3'd0;
	localparam status_t ST_TRUNCATED    = 3'd1;
	localparam status_t ST_FIXED_BIT    = 3'd2;
	localparam status_t ST_UNSUPPORTED  = 3'd3;
	localparam status_t ST_CID_TOO_LONG = 3'd4;
	localparam status_t ST_LEN_MISMATCH = 3'd5;

	localparam int unsigned MAX_DATAGRAM_BYTES = 65535;
	localparam int unsigned MAX_CID_BYTES      = 20;
	localparam logic [31:0] QUIC_VERSION_1     = 32'd1;

	localparam logic [1:0] LT_INITIAL   = 2'b00;
	localparam logic [1:0] LT_HANDSHAKE = 2'b10;

endpackage

>>> hw/rtl/quic_long_header_length_parser.sv
// An accepted byte is held in the input register, and its result is then registered in the output register.
// Throughput: one byte per cycle; the input register only stalls while a
// result sits unaccepted in the output register.
// Reset: arst_n clears the parse to idle, empties both registers and sets
// accepted_version to QUIC version 1.
// ----------------------------------------------------------------------------
// quic_long_header_length_parser
// Walks a coalesced datagram byte by byte and reports the current packet's
// length, or why its header is rejected, at most once per packet.
// ----------------------------------------------------------------------------
module quic_long_header_length_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [31:0]      cfg_wdata,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic             packet_start,
	input  logic [15:0]      bytes_left,
	output logic             out_valid,
	input  logic             out_stall,
	output qlh_pkg::status_t status,
	output logic [15:0]      pkt_len
);
	import qlh_pkg::*;

	typedef enum logic [11:0] {
		PH_IDLE         = 12'b0000_0000_0001,
		PH_VERSION      = 12'b0000_0000_0010,
		PH_DCID_LEN     = 12'b0000_0000_0100,
		PH_DCID         = 12'b0000_0000_1000,
		PH_SCID_LEN     = 12'b0000_0001_0000,
		PH_SCID         = 12'b0000_0010_0000,
		PH_TOKLEN_FIRST = 12'b0000_0100_0000,
		PH_TOKLEN_MORE  = 12'b0000_1000_0000,
		PH_TOKEN        = 12'b0001_0000_0000,
		PH_PAYLEN_FIRST = 12'b0010_0000_0000,
		PH_PAYLEN_MORE  = 12'b0100_0000_0000,
		PH_DONE         = 12'b1000_0000_0000
	} phase_t;

	logic [31:0] accepted_version_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic [15:0] left_s1;

	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] length_q;

	phase_t      phase_q, phase_d;
	logic [1:0]  type_q, type_d;
	logic [31:0] ver_q, ver_d;
	logic [15:0] skip_q, skip_d;
	logic [15:0] vv_q, vv_d;
	logic        big_q, big_d;
	logic [2:0]  due_q, due_d;
	logic [15:0] cons_q, cons_d;

	logic        advance;
	logic        fire;
	status_t     fire_status;
	logic [15:0] fire_len;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_version_q <= QUIC_VERSION_1;
		end else if (cfg_we) begin
			accepted_version_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= data_byte;
			start_s1 <= packet_start;
			left_s1  <= bytes_left;
		end
	end

	always_comb begin
		logic [15:0] left;
		logic [15:0] rem;
		logic [15:0] skip_dec;
		logic [16:0] len_sum;
		logic        vdone;

		phase_d     = phase_q;
		type_d      = type_q;
		ver_d       = ver_q;
		skip_d      = skip_q;
		vv_d        = vv_q;
		big_d       = big_q;
		due_d       = due_q;
		cons_d      = cons_q;
		fire        = 1'b0;
		fire_status = ST_OK;
		fire_len    = '0;
		vdone       = 1'b0;
		len_sum     = '0;

		left     = (left_s1 == 16'd0) ? 16'd1 : left_s1;
		rem      = left - 16'd1;
		skip_dec = (skip_q != 16'd0) ? skip_q - 16'd1 : skip_q;

		if (start_s1) begin
			cons_d = 16'd1;
			ver_d  = '0;
			vv_d   = '0;
			big_d  = 1'b0;
			due_d  = '0;
			skip_d = '0;
			type_d = '0;
			if (!byte_s1[7]) begin
				// short header runs to the end of the datagram
				fire     = 1'b1;
				fire_len = left;
			end else if (!byte_s1[6]) begin
				fire        = 1'b1;
				fire_status = ST_FIXED_BIT;
			end else begin
				type_d  = byte_s1[5:4];
				skip_d  = 16'd4;
				phase_d = PH_VERSION;
				if (left == 16'd1) begin
					fire        = 1'b1;
					fire_status = ST_TRUNCATED;
				end
			end
		end else if (phase_q != PH_IDLE && phase_q != PH_DONE) begin
			if (cons_q != 16'hFFFF) begin
				cons_d = cons_q + 16'd1;
			end
			unique case (phase_q) inside
				PH_VERSION: begin
					ver_d  = {ver_q[23:0], byte_s1};
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						if (ver_d != accepted_version_q) begin
							fire        = 1'b1;
							fire_status = ST_UNSUPPORTED;
						end else begin
							phase_d = PH_DCID_LEN;
						end
					end
				end
				PH_DCID_LEN, PH_SCID_LEN: begin
					if (byte_s1 > 8'(MAX_CID_BYTES)) begin
						fire        = 1'b1;
						fire_status = ST_CID_TOO_LONG;
					end else if (byte_s1 == 8'd0) begin
						if (phase_q == PH_DCID_LEN) begin
							phase_d = PH_SCID_LEN;
						end else if (type_q == LT_INITIAL) begin
							phase_d = PH_TOKLEN_FIRST;
						end else if (type_q == LT_HANDSHAKE) begin
							phase_d = PH_PAYLEN_FIRST;
						end else begin
							fire        = 1'b1;
							fire_status = ST_UNSUPPORTED;
						end
					end else begin
						skip_d  = {8'd0, byte_s1};
						phase_d = (phase_q == PH_DCID_LEN) ? PH_DCID : PH_SCID;
					end
				end
				PH_DCID: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_d = PH_SCID_LEN;
					end
				end
				PH_SCID: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						if (type_q == LT_INITIAL) begin
							phase_d = PH_TOKLEN_FIRST;
						end else if (type_q == LT_HANDSHAKE) begin
							phase_d = PH_PAYLEN_FIRST;
						end else begin
							fire        = 1'b1;
							fire_status = ST_UNSUPPORTED;
						end
					end
				end
				PH_TOKLEN_FIRST, PH_PAYLEN_FIRST: begin
					vv_d  = {10'd0, byte_s1[5:0]};
					big_d = 1'b0;
					case (byte_s1[7:6])
						2'd0:    due_d = 3'd0;
						2'd1:    due_d = 3'd1;
						2'd2:    due_d = 3'd3;
						default: due_d = 3'd7;
					endcase
					if (due_d == 3'd0) begin
						vdone = 1'b1;
					end else begin
						phase_d = (phase_q == PH_TOKLEN_FIRST) ? PH_TOKLEN_MORE
						                                       : PH_PAYLEN_MORE;
					end
				end
				PH_TOKLEN_MORE, PH_PAYLEN_MORE: begin
					// keep the low 16 bits; anything above only marks the value as too big
					vv_d  = {vv_q[7:0], byte_s1};
					big_d = big_q || (vv_q[15:8] != 8'd0);
					if (due_q != 3'd0) begin
						due_d = due_q - 3'd1;
					end
					if (due_d == 3'd0) begin
						vdone = 1'b1;
					end
				end
				PH_TOKEN: begin
					skip_d = skip_dec;
					if (skip_dec == 16'd0) begin
						phase_d = PH_PAYLEN_FIRST;
					end
				end
				default: begin
				end
			endcase

			if (vdone) begin
				if (big_d || vv_d > rem) begin
					fire        = 1'b1;
					fire_status = ST_LEN_MISMATCH;
				end else if (phase_q == PH_TOKLEN_FIRST || phase_q == PH_TOKLEN_MORE) begin
					if (vv_d == 16'd0) begin
						phase_d = PH_PAYLEN_FIRST;
					end else begin
						skip_d  = vv_d;
						phase_d = PH_TOKEN;
					end
				end else begin
					len_sum = {1'b0, cons_d} + {1'b0, vv_d};
					fire    = 1'b1;
					if (len_sum > 17'(MAX_DATAGRAM_BYTES)) begin
						fire_status = ST_LEN_MISMATCH;
					end else begin
						fire_len = len_sum[15:0];
					end
				end
			end

			if (!fire && left == 16'd1) begin
				fire        = 1'b1;
				fire_status = ST_TRUNCATED;
			end
		end

		if (fire) begin
			phase_d = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			type_q      <= '0;
			ver_q       <= '0;
			skip_q      <= '0;
			vv_q        <= '0;
			big_q       <= 1'b0;
			due_q       <= '0;
			cons_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && fire;
			if (valid_s1) begin
				phase_q <= phase_d;
				type_q  <= type_d;
				ver_q   <= ver_d;
				skip_q  <= skip_d;
				vv_q    <= vv_d;
				big_q   <= big_d;
				due_q   <= due_d;
				cons_q  <= cons_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (advance && valid_s1 && fire) begin
			status_q <= fire_status;
			length_q <= fire_len;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pkt_len   = length_q;

endmodule

>>> hw/rtl/qlh_checker.sv
// ----------------------------------------------------------------------------
// qlh_checker
// Port-level checks on the QUIC long header length parser.
// ----------------------------------------------------------------------------
module qlh_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input qlh_pkg::status_t status,
	input logic [15:0]      pkt_len
);
	import qlh_pkg::*;

	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// the input side backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with the output free");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_LEN_MISMATCH)
		else $error("status code out of range");

	a_err_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> pkt_len == 16'd0)
		else $error("length reported with an error status");

	a_ok_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> pkt_len != 16'd0)
		else $error("accepted packet with zero length");

endmodule

bind quic_long_header_length_parser qlh_checker u_qlh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.pkt_len   (pkt_len)
);

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream check of the QUIC long header length parser: coalesced
// datagrams of well-formed Initial and Handshake packets, short headers,
// damaged headers and stray bytes go in one byte per request; every packet
// verdict coming out is compared against an in-bench header walker.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import qlh_pkg::*;

	localparam logic [1:0] LT_ZERO_RTT = 2'b01;
	localparam logic [1:0] LT_RETRY    = 2'b11;
	localparam int PHASES       = 6;
	localparam int ITEMS_PHASE  = 50;
	localparam int HOLD_AT      = 60;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 4;
	localparam int MAX_PRINTS   = 40;

	typedef enum logic [3:0] {
		HP_IDLE, HP_VERSION, HP_DCID_LEN, HP_DCID, HP_SCID_LEN, HP_SCID,
		HP_TOKLEN_FIRST, HP_TOKLEN_MORE, HP_TOKEN, HP_PAYLEN_FIRST,
		HP_PAYLEN_MORE, HP_DONE
	} hdr_phase_e;

	typedef enum int {
		PK_INITIAL, PK_HANDSHAKE, PK_SHORT, PK_FIXED_CLEAR, PK_BAD_VERSION,
		PK_CID_LONG, PK_BAD_TYPE, PK_PAYLEN_BIG, PK_TOKLEN_BIG
	} pkt_kind_e;

	typedef struct packed {
		logic [7:0]  b;
		logic        s;
		logic [15:0] left;
	} byte_req_t;

	typedef struct packed {
		status_t     st;
		logic [15:0] len;
	} pkt_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        packet_start = 1'b0;
	logic [15:0] bytes_left = 16'd1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	status_t     status;
	logic [15:0] pkt_len;

	quic_long_header_length_parser DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.packet_start (packet_start),
		.bytes_left   (bytes_left),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.pkt_len      (pkt_len)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// header walker state
	logic [31:0]  model_version = QUIC_VERSION_1;
	hdr_phase_e   hdr_phase = HP_IDLE;
	logic [1:0]   hdr_type = '0;
	logic [31:0]  ver_acc = '0;
	logic [15:0]  skip_left = '0;
	logic [61:0]  vint_acc = '0;
	logic [2:0]   vint_due = '0;
	logic [15:0]  pkt_count = '0;

	pkt_verdict_t verdict_q[$];
	byte_req_t    req_q[$];
	byte_req_t    nxt_req;
	pkt_verdict_t want;

	int err_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int reqs_taken = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;

	// stimulus builder state
	logic [7:0]  dg_b[$];
	bit          dg_s[$];
	int          gen_items = 0;
	int          gen_extra = 0;
	logic [31:0] gen_version = QUIC_VERSION_1;

	task automatic report_error(input string msg);
		if (err_count < MAX_PRINTS)
			$display("ERROR %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic post_verdict(input status_t st, input logic [15:0] len);
		pkt_verdict_t v;
		v.st = st;
		v.len = (st == ST_OK) ? len : 16'd0;
		verdict_q = {verdict_q, v};
		hdr_phase = HP_DONE;
	endtask

	// HP_DONE here means the long type is rejected
	function automatic hdr_phase_e phase_after_scid();
		if (hdr_type == LT_INITIAL)
			return HP_TOKLEN_FIRST;
		if (hdr_type == LT_HANDSHAKE)
			return HP_PAYLEN_FIRST;
		return HP_DONE;
	endfunction

	task automatic walk_header_byte(input logic [7:0] b, input logic first,
			input logic [15:0] left_in);
		logic [16:0] left;
		logic [16:0] rem;
		logic [16:0] total;
		logic        vint_done;
		hdr_phase_e  nxt;
		left = (left_in == 16'd0) ? 17'd1 : {1'b0, left_in};
		rem = left - 17'd1;
		vint_done = 1'b0;
		if (first) begin
			pkt_count = 16'd1;
			ver_acc = '0;
			vint_acc = '0;
			vint_due = '0;
			skip_left = '0;
			hdr_type = '0;
			if (!b[7]) begin
				if (left > MAX_DATAGRAM_BYTES)
					post_verdict(ST_LEN_MISMATCH, '0);
				else
					post_verdict(ST_OK, left[15:0]);
				return;
			end
			if (!b[6]) begin
				post_verdict(ST_FIXED_BIT, '0);
				return;
			end
			hdr_type = b[5:4];
			skip_left = 16'd4;
			hdr_phase = HP_VERSION;
		end else begin
			if (hdr_phase == HP_IDLE || hdr_phase == HP_DONE)
				return;
			if (pkt_count != 16'hFFFF)
				pkt_count++;
			case (hdr_phase)
				HP_VERSION: begin
					ver_acc = {ver_acc[23:0], b};
					if (skip_left != 0)
						skip_left--;
					if (skip_left == 0) begin
						if (ver_acc != model_version) begin
							post_verdict(ST_UNSUPPORTED, '0);
							return;
						end
						hdr_phase = HP_DCID_LEN;
					end
				end
				HP_DCID_LEN, HP_SCID_LEN: begin
					if (b > MAX_CID_BYTES) begin
						post_verdict(ST_CID_TOO_LONG, '0);
						return;
					end
					if (b != 0) begin
						skip_left = {8'd0, b};
						hdr_phase = (hdr_phase == HP_DCID_LEN) ? HP_DCID : HP_SCID;
					end else if (hdr_phase == HP_DCID_LEN) begin
						hdr_phase = HP_SCID_LEN;
					end else begin
						nxt = phase_after_scid();
						if (nxt == HP_DONE) begin
							post_verdict(ST_UNSUPPORTED, '0);
							return;
						end
						hdr_phase = nxt;
					end
				end
				HP_DCID: begin
					if (skip_left != 0)
						skip_left--;
					if (skip_left == 0)
						hdr_phase = HP_SCID_LEN;
				end
				HP_SCID: begin
					if (skip_left != 0)
						skip_left--;
					if (skip_left == 0) begin
						nxt = phase_after_scid();
						if (nxt == HP_DONE) begin
							post_verdict(ST_UNSUPPORTED, '0);
							return;
						end
						hdr_phase = nxt;
					end
				end
				HP_TOKLEN_FIRST, HP_PAYLEN_FIRST: begin
					vint_acc = {56'd0, b[5:0]};
					vint_due = 3'((4'd1 << b[7:6]) - 4'd1);
					if (vint_due == 0)
						vint_done = 1'b1;
					else
						hdr_phase = (hdr_phase == HP_TOKLEN_FIRST) ? HP_TOKLEN_MORE
							: HP_PAYLEN_MORE;
				end
				HP_TOKLEN_MORE, HP_PAYLEN_MORE: begin
					vint_acc = {vint_acc[53:0], b};
					if (vint_due != 0)
						vint_due--;
					if (vint_due == 0)
						vint_done = 1'b1;
				end
				HP_TOKEN: begin
					if (skip_left != 0)
						skip_left--;
					if (skip_left == 0)
						hdr_phase = HP_PAYLEN_FIRST;
				end
				default: return;
			endcase
			if (vint_done) begin
				if (vint_acc > rem) begin
					post_verdict(ST_LEN_MISMATCH, '0);
					return;
				end
				if (hdr_phase == HP_TOKLEN_FIRST || hdr_phase == HP_TOKLEN_MORE) begin
					if (vint_acc == 0) begin
						hdr_phase = HP_PAYLEN_FIRST;
					end else begin
						skip_left = vint_acc[15:0];
						hdr_phase = HP_TOKEN;
					end
				end else begin
					total = {1'b0, pkt_count} + vint_acc[16:0];
					if (total > MAX_DATAGRAM_BYTES)
						post_verdict(ST_LEN_MISMATCH, '0);
					else
						post_verdict(ST_OK, total[15:0]);
					return;
				end
			end
		end
		// last datagram byte with the length still unknown
		if (left == 17'd1)
			post_verdict(ST_TRUNCATED, '0);
	endtask

	// ---------------- stimulus builders ----------------

	task automatic push_req(input logic [7:0] b, input logic s, input logic [15:0] left);
		byte_req_t r;
		r.b = b;
		r.s = s;
		r.left = left;
		req_q = {req_q, r};
		gen_items++;
	endtask

	task automatic put_byte(input logic [7:0] b, input bit first);
		dg_b = {dg_b, b};
		dg_s = {dg_s, first};
	endtask

	task automatic put_version(input logic [31:0] v);
		for (int i = 3; i >= 0; i--)
			put_byte(v[8*i +: 8], 0);
	endtask

	task automatic put_varint(input logic [61:0] v, input int code);
		logic [63:0] enc;
		int n;
		n = 1 << code;
		enc = {2'b00, v};
		enc[8*n-1 -: 2] = 2'(code);
		for (int i = n - 1; i >= 0; i--)
			put_byte(enc[8*i +: 8], 0);
	endtask

	// shortest encoding most of the time, otherwise a random one no shorter
	function automatic int varint_code(input logic [61:0] v);
		int c;
		c = (v < 64) ? 0 : (v < 16384) ? 1 : (v < 62'h4000_0000) ? 2 : 3;
		if ($urandom_range(0, 3) == 0)
			c = $urandom_range(c, 3);
		return c;
	endfunction

	task automatic put_big_varint();
		put_varint({6'($urandom_range(1, 63)), 32'($urandom), 24'($urandom)}, 3);
	endtask

	function automatic int pick_cid_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return 0;
		if (r < 4)
			return MAX_CID_BYTES;
		return $urandom_range(0, MAX_CID_BYTES);
	endfunction

	task automatic put_cid(input int len);
		put_byte(8'(len), 0);
		repeat (len)
			put_byte(8'($urandom), 0);
	endtask

	task automatic put_tail();
		repeat ($urandom_range(0, 3))
			put_byte(8'($urandom), 0);
	endtask

	function automatic pkt_kind_e pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return PK_INITIAL;
		if (r < 70) return PK_HANDSHAKE;
		if (r < 75) return PK_SHORT;
		if (r < 80) return PK_FIXED_CLEAR;
		if (r < 85) return PK_BAD_VERSION;
		if (r < 89) return PK_CID_LONG;
		if (r < 93) return PK_BAD_TYPE;
		if (r < 97) return PK_PAYLEN_BIG;
		return PK_TOKLEN_BIG;
	endfunction

	task automatic build_packet(input pkt_kind_e kind);
		logic [1:0]  lt;
		logic [31:0] ver;
		int          tok;
		int          n_fill;
		logic [61:0] pay;
		case (kind)
			PK_SHORT: begin
				put_byte({1'b0, 7'($urandom)}, 1);
				return;
			end
			PK_FIXED_CLEAR: begin
				put_byte({2'b10, 6'($urandom)}, 1);
				put_tail();
				return;
			end
			PK_INITIAL, PK_TOKLEN_BIG: lt = LT_INITIAL;
			PK_HANDSHAKE: lt = LT_HANDSHAKE;
			PK_PAYLEN_BIG: lt = $urandom_range(0, 1) ? LT_INITIAL : LT_HANDSHAKE;
			PK_BAD_TYPE: lt = $urandom_range(0, 1) ? LT_RETRY : LT_ZERO_RTT;
			default: lt = 2'($urandom);
		endcase
		put_byte({2'b11, lt, 4'($urandom)}, 1);
		ver = gen_version;
		if (kind == PK_BAD_VERSION)
			ver = ver ^ (32'($urandom) | (32'd1 << $urandom_range(0, 31)));
		put_version(ver);
		if (kind == PK_BAD_VERSION) begin
			put_tail();
			return;
		end
		if (kind == PK_CID_LONG) begin
			if ($urandom_range(0, 1))
				put_cid(pick_cid_len());
			put_byte(8'($urandom_range(MAX_CID_BYTES + 1, 255)), 0);
			put_tail();
			return;
		end
		put_cid(pick_cid_len());
		put_cid(pick_cid_len());
		if (kind == PK_BAD_TYPE) begin
			put_tail();
			return;
		end
		if (lt == LT_INITIAL) begin
			if (kind == PK_TOKLEN_BIG) begin
				put_big_varint();
				put_tail();
				return;
			end
			tok = $urandom_range(0, 6);
			put_varint(62'(tok), varint_code(62'(tok)));
			repeat (tok)
				put_byte(8'($urandom), 0);
		end
		if (kind == PK_PAYLEN_BIG) begin
			put_big_varint();
			put_tail();
			return;
		end
		n_fill = $urandom_range(0, 12);
		pay = 62'(n_fill) + 62'($urandom_range(0, gen_extra));
		put_varint(pay, varint_code(pay));
		repeat (n_fill)
			put_byte(8'($urandom), 0);
	endtask

	// flat: every byte carries bytes_left = extra, else count down to extra + 1
	task automatic flush_datagram(input int extra, input bit flat);
		byte_req_t r;
		int total;
		total = dg_b.size();
		foreach (dg_b[i]) begin
			r.b = dg_b[i];
			r.s = dg_s[i];
			r.left = flat ? 16'(extra) : 16'(total - i + extra);
			req_q = {req_q, r};
		end
		gen_items += total;
		dg_b.delete();
		dg_s.delete();
	endtask

	task automatic gen_datagram();
		int n_pk;
		int cut;
		pkt_kind_e kind;
		gen_extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65000) : 0;
		n_pk = $urandom_range(1, 3);
		for (int p = 0; p < n_pk; p++) begin
			kind = pick_kind();
			build_packet(kind);
			if (kind == PK_SHORT)
				break;
		end
		// cut the datagram short now and then
		if (gen_extra == 0 && $urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, dg_b.size());
			while (dg_b.size() > cut) begin
				void'(dg_b.pop_back());
				void'(dg_s.pop_back());
			end
		end
		flush_datagram(gen_extra, 1'b0);
	endtask

	task automatic gen_noise();
		logic [15:0] left;
		left = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
		push_req(8'($urandom), 1'($urandom), left);
	endtask

	task automatic run_directed();
		// short headers at the bytes_left extremes, zero counts as the last byte
		push_req(8'h00, 1'b1, 16'd0);
		push_req(8'h7F, 1'b1, 16'hFFFF);
		// fixed bit clear, then a stray byte after the verdict
		push_req(8'hBF, 1'b1, 16'd2);
		push_req(8'hFF, 1'b0, 16'd1);
		// abandoned parse, then a minimal Handshake ending on the last byte
		put_byte(8'hC0, 1);
		put_byte(8'h00, 0);
		put_byte(8'hE0, 1);
		put_version(gen_version);
		put_cid(0);
		put_cid(0);
		put_byte(8'h00, 0);
		flush_datagram(0, 1'b0);
		// Retry type rejected on the last byte rather than truncated
		put_byte(8'hF0, 1);
		put_version(gen_version);
		put_cid(0);
		put_cid(0);
		flush_datagram(0, 1'b0);
		// connection ID length at its maximum code
		put_byte(8'hC0, 1);
		put_version(gen_version);
		put_byte(8'hFF, 0);
		flush_datagram(100, 1'b1);
		// payload length fits bytes left but the packet overruns the max size
		put_byte(8'hE0, 1);
		put_version(gen_version);
		put_cid(0);
		put_cid(0);
		put_varint(62'd65534, 2);
		flush_datagram(65535, 1'b1);
		// Initial with a one-byte token
		put_byte(8'hC0, 1);
		put_version(gen_version);
		put_cid(0);
		put_cid(0);
		put_varint(62'd1, 0);
		put_byte(8'hAB, 0);
		put_byte(8'h00, 0);
		flush_datagram(0, 1'b0);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (req_q.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (SETTLE)
			@(negedge clk);
	endtask

	// ---------------- driver ----------------

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				walk_header_byte(data_byte, packet_start, bytes_left);
				reqs_taken <= reqs_taken + 1;
			end
			if (!in_valid || !in_stall) begin
				if (req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					nxt_req = req_q.pop_front();
					data_byte <= nxt_req.b;
					packet_start <= nxt_req.s;
					bytes_left <= nxt_req.left;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// one long hold-off of the receiver so the block backs up into its input
	always @(posedge clk) begin
		if (!arst_n) begin
			hold_cycles <= 0;
		end else if (!hold_done && reqs_taken >= HOLD_AT) begin
			hold_cycles <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_cycles != 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= (hold_cycles != 0) || ($urandom_range(0, 99) < rx_idle_pct);
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					report_error($sformatf("unexpected verdict status %0d length %0d",
						status, pkt_len));
				end else begin
					want = verdict_q.pop_front();
					if (status !== want.st)
						report_error($sformatf("status %0d, want %0d", status, want.st));
					if (pkt_len !== want.len)
						report_error($sformatf("pkt_len %0d, want %0d",
							pkt_len, want.len));
				end
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		logic [31:0] ver;
		int target;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				wait_idle();
				case (ph)
					1: ver = 32'hFFFF_FFFF;
					2: ver = 32'h0000_0000;
					4: ver = QUIC_VERSION_1;
					default: ver = 32'($urandom);
				endcase
				@(posedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= ver;
				@(posedge clk);
				cfg_we <= 1'b0;
				model_version = ver;
				gen_version = ver;
				@(negedge clk);
			end
			if (ph < 2) begin
				tx_idle_pct = 24;
				rx_idle_pct = 84;
			end else if (ph < 4) begin
				tx_idle_pct = 84;
				rx_idle_pct = 24;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (ph == 0)
				run_directed();
			target = gen_items + ITEMS_PHASE;
			while (gen_items < target) begin
				if ($urandom_range(0, 9) == 0)
					gen_noise();
				else
					gen_datagram();
			end
		end
		wait_idle();
		repeat (8)
			@(negedge clk);
		if (verdict_q.size() != 0)
			report_error($sformatf("%0d verdicts never arrived", verdict_q.size()));
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/qlh_pkg.sv
hw/rtl/quic_long_header_length_parser.sv
hw/rtl/qlh_checker.sv
sim/tb_top.sv
